>>> sv/wavp_pkg.sv
// shared types and constants for the wav pcm16 stream parser
// no dependencies; imported by every module of the block
package wavp_pkg;

    // chunk walk phases
    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_CHUNK_HDR = 3'd1,
        PH_PAYLOAD   = 3'd2,
        PH_PAD       = 3'd3,
        PH_DONE      = 3'd4
    } phase_t;

    // chunk kinds
    typedef enum logic [1:0] {
        CK_OTHER = 2'd0,
        CK_FMT   = 2'd1,
        CK_DATA  = 2'd2
    } chunk_kind_t;

    // seen flag positions
    localparam int SEEN_FMT   = 0;
    localparam int SEEN_DATA  = 1;
    localparam int SEEN_EXTRA = 2;

    // status codes in priority order
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_TOO_LARGE  = 4'd1;
    localparam logic [3:0] ST_BAD_HEADER = 4'd2;
    localparam logic [3:0] ST_RIFF_SIZE  = 4'd3;
    localparam logic [3:0] ST_TRUNC_HDR  = 4'd4;
    localparam logic [3:0] ST_TRUNC_BODY = 4'd5;
    localparam logic [3:0] ST_FMT_DUP    = 4'd6;
    localparam logic [3:0] ST_FMT_CODEC  = 4'd7;
    localparam logic [3:0] ST_FMT_RANGE  = 4'd8;
    localparam logic [3:0] ST_FMT_SIZES  = 4'd9;
    localparam logic [3:0] ST_DATA_ORDER = 4'd10;
    localparam logic [3:0] ST_NO_PCM     = 4'd11;
    localparam logic [3:0] ST_PCM_LARGE  = 4'd12;

    // four character tags, first character in the low byte
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // format limits
    localparam logic [31:0] RATE_MIN  = 32'd8000;
    localparam logic [31:0] RATE_MAX  = 32'd192000;
    localparam logic [31:0] FMT_LEN   = 32'd16;
    localparam logic [31:0] FMT_LEN_X = 32'd18;

    // result queue depth
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // one queued result: a sample, or a snapshot for the final status
    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
        logic               channel;
        logic               end_of_run;
        logic [31:0]        byte_count;
        logic [31:0]        riff_length;
        logic [3:0]         first_error;
        logic [2:0]         seen;
        logic [31:0]        pcm_length;
        logic [15:0]        chan_word;
        logic [17:0]        rate;
    } entry_t;

endpackage

>>> sv/wavp_front.sv
// front part: walks the riff chunks one byte per beat and queues results
// depends on wavp_pkg
module wavp_front
    import wavp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_beat,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    output logic [1:0]  wr_cnt,
    output entry_t      wr0,
    output entry_t      wr1
);

    phase_t      phase_reg, phase_next;
    chunk_kind_t ckind_reg, ckind_next;
    logic [31:0] bc_reg, bc_next;
    logic [31:0] riff_reg, riff_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] off_reg, off_next;
    logic [15:0] w0_reg, w0_next, w1_reg, w1_next, w4_reg, w4_next;
    logic [15:0] w5_reg, w5_next, w6_reg, w6_next;
    logic [31:0] w2_reg, w2_next, w3_reg, w3_next;
    logic [2:0]  seen_reg, seen_next;
    logic [7:0]  low_reg, low_next;
    logic        tog_reg, tog_next;
    logic [31:0] pcm_reg, pcm_next;
    logic [3:0]  err_reg, err_next;

    // per byte walk
    always_comb
    begin
        logic [31:0] idx;
        logic [32:0] total;
        logic [32:0] padded;
        logic [32:0] remain;
        logic        do_hdr;
        logic        do_fin;
        logic        do_start;
        logic        stopped;
        logic        emit;
        logic signed [15:0] smp;
        logic        smp_ch;
        entry_t      st;

        phase_next = phase_reg;
        ckind_next = ckind_reg;
        riff_next  = riff_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        off_next   = off_reg;
        w0_next    = w0_reg;
        w1_next    = w1_reg;
        w2_next    = w2_reg;
        w3_next    = w3_reg;
        w4_next    = w4_reg;
        w5_next    = w5_reg;
        w6_next    = w6_reg;
        seen_next  = seen_reg;
        low_next   = low_reg;
        tog_next   = tog_reg;
        pcm_next   = pcm_reg;
        err_next   = err_reg;
        do_hdr     = 1'b0;
        do_fin     = 1'b0;
        do_start   = 1'b0;
        stopped    = 1'b0;
        emit       = 1'b0;
        smp        = '0;
        smp_ch     = 1'b0;
        idx        = bc_reg;
        bc_next    = (bc_reg == 32'hFFFF_FFFF) ? bc_reg : bc_reg + 32'd1;
        total      = {1'b0, riff_reg} + 33'd8;
        padded     = '0;
        remain     = '0;
        st         = '0;

        // byte by phase
        case (phase_reg)
            PH_HEADER:
            begin
                if (idx < 32'd4 || (idx >= 32'd8 && idx < 32'd12))
                    tag_next = {data_byte, tag_reg[31:8]};
                else if (idx < 32'd8)
                    riff_next = riff_reg | ({24'd0, data_byte} << {idx[1:0], 3'b000});
                if (idx == 32'd3 && tag_next != TAG_RIFF)
                begin
                    err_next = ST_BAD_HEADER;
                    phase_next = PH_DONE;
                end
                else if (idx == 32'd11)
                begin
                    if (tag_next != TAG_WAVE)
                    begin
                        err_next = ST_BAD_HEADER;
                        phase_next = PH_DONE;
                    end
                    else
                        do_start = 1'b1;
                end
            end
            PH_CHUNK_HDR:
            begin
                if (off_reg < 32'd4)
                    tag_next = {data_byte, tag_reg[31:8]};
                else
                    len_next = len_reg | ({24'd0, data_byte} << {off_reg[1:0], 3'b000});
                off_next = off_reg + 32'd1;
                if (off_next >= 32'd8)
                    do_hdr = 1'b1;
            end
            PH_PAYLOAD:
            begin
                if (ckind_reg == CK_FMT && off_reg < FMT_LEN_X)
                begin
                    case (off_reg[4:0])
                        5'd0:  w0_next[7:0]   = data_byte;
                        5'd1:  w0_next[15:8]  = data_byte;
                        5'd2:  w1_next[7:0]   = data_byte;
                        5'd3:  w1_next[15:8]  = data_byte;
                        5'd4:  w2_next[7:0]   = data_byte;
                        5'd5:  w2_next[15:8]  = data_byte;
                        5'd6:  w2_next[23:16] = data_byte;
                        5'd7:  w2_next[31:24] = data_byte;
                        5'd8:  w3_next[7:0]   = data_byte;
                        5'd9:  w3_next[15:8]  = data_byte;
                        5'd10: w3_next[23:16] = data_byte;
                        5'd11: w3_next[31:24] = data_byte;
                        5'd12: w4_next[7:0]   = data_byte;
                        5'd13: w4_next[15:8]  = data_byte;
                        5'd14: w5_next[7:0]   = data_byte;
                        5'd15: w5_next[15:8]  = data_byte;
                        5'd16: w6_next[7:0]   = data_byte;
                        5'd17: w6_next[15:8]  = data_byte;
                        default: ;
                    endcase
                end
                else if (ckind_reg == CK_DATA)
                begin
                    if (off_reg[0])
                    begin
                        emit   = 1'b1;
                        smp    = {data_byte, low_reg};
                        smp_ch = tog_reg;
                        if (w1_reg == 16'd2)
                            tog_next = ~tog_reg;
                    end
                    else
                        low_next = data_byte;
                end
                off_next = off_reg + 32'd1;
                if (off_next == len_reg)
                    do_fin = 1'b1;
            end
            PH_PAD:
                do_start = 1'b1;
            default: ;
        endcase

        // chunk header complete
        if (do_hdr)
        begin
            padded = {1'b0, len_next} + {32'd0, len_next[0]};
            remain = total - {1'b0, bc_next};
            if (padded > remain)
            begin
                err_next = ST_TRUNC_BODY;
                phase_next = PH_DONE;
                stopped = 1'b1;
            end
            else if (tag_next == TAG_FMT)
            begin
                ckind_next = CK_FMT;
                if (seen_reg[SEEN_FMT] || len_next < FMT_LEN)
                begin
                    err_next = ST_FMT_DUP;
                    phase_next = PH_DONE;
                    stopped = 1'b1;
                end
                else
                begin
                    w0_next = '0; w1_next = '0; w2_next = '0; w3_next = '0;
                    w4_next = '0; w5_next = '0; w6_next = '0;
                end
            end
            else if (tag_next == TAG_DATA)
            begin
                ckind_next = CK_DATA;
                if (seen_reg[SEEN_DATA] || !seen_reg[SEEN_FMT])
                begin
                    err_next = ST_DATA_ORDER;
                    phase_next = PH_DONE;
                    stopped = 1'b1;
                end
                else
                begin
                    pcm_next = len_next;
                    seen_next[SEEN_DATA] = 1'b1;
                    tog_next = 1'b0;
                end
            end
            else
            begin
                ckind_next = CK_OTHER;
                seen_next[SEEN_EXTRA] = 1'b1;
            end
            if (!stopped)
            begin
                phase_next = PH_PAYLOAD;
                off_next = '0;
                if (len_next == 32'd0)
                    do_fin = 1'b1;
            end
        end

        // payload complete: validate format, then pad or next chunk
        if (do_fin)
        begin
            if (ckind_next == CK_FMT)
            begin
                if (w0_next != 16'd1 || w5_next != 16'd16)
                begin
                    err_next = ST_FMT_CODEC;
                    phase_next = PH_DONE;
                    stopped = 1'b1;
                end
                else if (w2_next < RATE_MIN || w2_next > RATE_MAX
                         || (w1_next != 16'd1 && w1_next != 16'd2))
                begin
                    err_next = ST_FMT_RANGE;
                    phase_next = PH_DONE;
                    stopped = 1'b1;
                end
                else if ((len_next != FMT_LEN && (len_next != FMT_LEN_X || w6_next != 16'd0))
                         || {1'b0, w4_next} != {w1_next, 1'b0}
                         || w3_next != ((w1_next == 16'd1) ? {w2_next[30:0], 1'b0}
                                                          : {w2_next[29:0], 2'b00}))
                begin
                    err_next = ST_FMT_SIZES;
                    phase_next = PH_DONE;
                    stopped = 1'b1;
                end
                else
                    seen_next[SEEN_FMT] = 1'b1;
            end
            if (!stopped)
            begin
                if (len_next[0])
                    phase_next = PH_PAD;
                else
                    do_start = 1'b1;
            end
        end

        // next chunk start or end of walk
        if (do_start)
        begin
            if ({1'b0, bc_next} >= total)
                phase_next = PH_DONE;
            else if (total - {1'b0, bc_next} < 33'd8)
            begin
                err_next = ST_TRUNC_HDR;
                phase_next = PH_DONE;
            end
            else
            begin
                phase_next = PH_CHUNK_HDR;
                off_next = '0;
                len_next = '0;
                tag_next = '0;
            end
        end

        // status snapshot
        st.kind        = 1'b1;
        st.end_of_run  = 1'b1;
        st.byte_count  = bc_next;
        st.riff_length = riff_next;
        st.first_error = err_next;
        st.seen        = seen_next;
        st.pcm_length  = pcm_next;
        st.chan_word   = w1_next;
        st.rate        = w2_next[17:0];

        wr0 = '0;
        wr1 = '0;
        wr0.sample     = smp;
        wr0.channel    = smp_ch;
        wr0.end_of_run = !is_last;
        if (emit)
        begin
            wr1 = st;
            wr_cnt = is_last ? 2'd2 : 2'd1;
        end
        else
        begin
            wr0 = st;
            wr_cnt = is_last ? 2'd1 : 2'd0;
        end
        if (!in_beat)
            wr_cnt = 2'd0;

        // back to reset after the last byte
        if (is_last)
        begin
            phase_next = PH_HEADER; ckind_next = CK_OTHER;
            bc_next = '0; riff_next = '0; tag_next = '0; len_next = '0; off_next = '0;
            w0_next = '0; w1_next = '0; w2_next = '0; w3_next = '0;
            w4_next = '0; w5_next = '0; w6_next = '0;
            seen_next = '0; low_next = '0; tog_next = 1'b0; pcm_next = '0; err_next = '0;
        end
    end

    // walk state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER; ckind_reg <= CK_OTHER;
            bc_reg <= '0; riff_reg <= '0; tag_reg <= '0; len_reg <= '0; off_reg <= '0;
            w0_reg <= '0; w1_reg <= '0; w2_reg <= '0; w3_reg <= '0;
            w4_reg <= '0; w5_reg <= '0; w6_reg <= '0;
            seen_reg <= '0; low_reg <= '0; tog_reg <= 1'b0; pcm_reg <= '0; err_reg <= '0;
        end
        else if (in_beat)
        begin
            phase_reg <= phase_next; ckind_reg <= ckind_next;
            bc_reg <= bc_next; riff_reg <= riff_next; tag_reg <= tag_next;
            len_reg <= len_next; off_reg <= off_next;
            w0_reg <= w0_next; w1_reg <= w1_next; w2_reg <= w2_next; w3_reg <= w3_next;
            w4_reg <= w4_next; w5_reg <= w5_next; w6_reg <= w6_next;
            seen_reg <= seen_next; low_reg <= low_next; tog_reg <= tog_next;
            pcm_reg <= pcm_next; err_reg <= err_next;
        end
    end

endmodule

>>> sv/wavp_queue.sv
// result queue between the walk and the output stage, two writes one read
// depends on wavp_pkg
module wavp_queue
    import wavp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    wr_cnt,
    input  entry_t        wr0,
    input  entry_t        wr1,
    input  logic          rd_en,
    output entry_t        rd_data,
    output logic          rd_valid,
    output logic          full,
    output logic [Q_AW:0] count
);

    entry_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg, rp_reg;
    logic [Q_AW:0]   cnt_reg;
    logic            rd_go;
    logic [Q_AW-1:0] wp_inc;

    assign rd_valid = (cnt_reg != '0);
    assign rd_go    = rd_en && rd_valid;
    assign rd_data  = mem_reg[rp_reg];
    assign wp_inc   = wp_reg + 1'b1;
    // room for the two results one byte may cause
    assign full     = (cnt_reg > (Q_AW+1)'(Q_DEPTH - 2));
    assign count    = cnt_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
            mem_reg[wp_reg] <= wr0;
        if (wr_cnt == 2'd2)
            mem_reg[wp_inc] <= wr1;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + Q_AW'(wr_cnt);
            if (rd_go)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (Q_AW+1)'(wr_cnt) - (Q_AW+1)'(rd_go);
        end
    end

endmodule

>>> sv/wavp_back.sv
// back part: resolves final status from the snapshot and holds the output beat
// depends on wavp_pkg
module wavp_back
    import wavp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  entry_t             head,
    input  logic               head_valid,
    output logic               head_pop,
    input  logic [31:0]        max_in,
    input  logic [31:0]        max_dec,
    input  logic               pop,
    output logic               empty,
    output logic               kind,
    output logic signed [15:0] sample,
    output logic               channel,
    output logic [3:0]         status,
    output logic [17:0]        rate_hz,
    output logic [1:0]         channel_count,
    output logic               extra_chunks,
    output logic               end_of_run
);

    logic               vld_reg;
    logic               kind_reg;
    logic signed [15:0] sample_reg;
    logic               chan_reg;
    logic [3:0]         st_reg;
    logic [17:0]        rate_reg;
    logic [1:0]         cc_reg;
    logic               extra_reg;
    logic               eor_reg;
    logic [3:0]         st_next;
    logic               part_frame;

    assign head_pop = head_valid && (!vld_reg || pop);

    // status by priority
    always_comb
    begin
        part_frame = (head.chan_word == 16'd2) ? (head.pcm_length[1:0] != 2'd0)
                                               : head.pcm_length[0];
        if (head.byte_count > max_in)
            st_next = ST_TOO_LARGE;
        else if (head.byte_count < 32'd12 || head.first_error == ST_BAD_HEADER)
            st_next = ST_BAD_HEADER;
        else if ({1'b0, head.riff_length} + 33'd8 != {1'b0, head.byte_count})
            st_next = ST_RIFF_SIZE;
        else if (head.first_error != ST_OK)
            st_next = head.first_error;
        else if (!head.seen[SEEN_FMT] || !head.seen[SEEN_DATA]
                 || head.pcm_length == 32'd0 || head.chan_word == 16'd0 || part_frame)
            st_next = ST_NO_PCM;
        else if (head.pcm_length > max_dec)
            st_next = ST_PCM_LARGE;
        else
            st_next = ST_OK;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (!vld_reg || pop)
            vld_reg <= head_valid;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            kind_reg   <= head.kind;
            sample_reg <= head.kind ? 16'sd0 : head.sample;
            chan_reg   <= head.kind ? 1'b0 : head.channel;
            eor_reg    <= head.end_of_run;
            if (head.kind)
            begin
                st_reg    <= st_next;
                rate_reg  <= (st_next == ST_OK) ? head.rate : '0;
                cc_reg    <= (st_next == ST_OK) ? head.chan_word[1:0] : '0;
                extra_reg <= (st_next == ST_OK) && head.seen[SEEN_EXTRA];
            end
            else
            begin
                st_reg    <= ST_OK;
                rate_reg  <= '0;
                cc_reg    <= '0;
                extra_reg <= 1'b0;
            end
        end
    end

    assign empty         = !vld_reg;
    assign kind          = kind_reg;
    assign sample        = sample_reg;
    assign channel       = chan_reg;
    assign status        = st_reg;
    assign rate_hz       = rate_reg;
    assign channel_count = cc_reg;
    assign extra_chunks  = extra_reg;
    assign end_of_run    = eor_reg;

endmodule

>>> sv/wav_pcm16_stream_parser.sv
// Parses a RIFF/WAVE file fed one byte per beat and returns PCM16 samples
// followed by one status result on the byte marked last; samples count only
// if that status is ok. A byte can be pushed every cycle while full is low; a
// byte that completes a sample and also ends the file yields two results, and
// the single output stage drains one result per cycle while pop is held, which
// sets the sustained rate at one byte per cycle when at most one result comes
// per byte. A four-entry queue decouples the walk from the output stage; full
// rises when fewer than two entries are free. Configuration writes are taken
// at any time and must happen while idle.
// depends on wavp_pkg, wavp_front, wavp_queue, wavp_back
module wav_pcm16_stream_parser
    import wavp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         data_byte,
    input  logic               is_last,
    output logic               empty,
    input  logic               pop,
    output logic               kind,
    output logic signed [15:0] sample,
    output logic               channel,
    output logic [3:0]         status,
    output logic [17:0]        rate_hz,
    output logic [1:0]         channel_count,
    output logic               extra_chunks,
    output logic               end_of_run,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam logic CFG_MAX_IN  = 1'b0;
    localparam logic CFG_MAX_DEC = 1'b1;

    logic [31:0]   max_in_reg;
    logic [31:0]   max_dec_reg;
    logic [1:0]    wr_cnt;
    entry_t        wr0, wr1, head;
    logic          head_valid, head_pop, in_beat;
    logic [Q_AW:0] q_count;

    assign cfg_ready = 1'b1;
    assign in_beat   = push && !full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_in_reg  <= 32'hFFFF_FFFF;
            max_dec_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_IN:  max_in_reg  <= cfg_data;
                CFG_MAX_DEC: max_dec_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // chunk walk
    wavp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (in_beat),
        .data_byte (data_byte),
        .is_last   (is_last),
        .wr_cnt    (wr_cnt),
        .wr0       (wr0),
        .wr1       (wr1)
    );

    // result queue
    wavp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cnt   (wr_cnt),
        .wr0      (wr0),
        .wr1      (wr1),
        .rd_en    (head_pop),
        .rd_data  (head),
        .rd_valid (head_valid),
        .full     (full),
        .count    (q_count)
    );

    // output stage
    wavp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .head_pop      (head_pop),
        .max_in        (max_in_reg),
        .max_dec       (max_dec_reg),
        .pop           (pop),
        .empty         (empty),
        .kind          (kind),
        .sample        (sample),
        .channel       (channel),
        .status        (status),
        .rate_hz       (rate_hz),
        .channel_count (channel_count),
        .extra_chunks  (extra_chunks),
        .end_of_run    (end_of_run)
    );

`ifndef ASSERT_OFF
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("result queue overflow");

    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind) |-> end_of_run)
        else $error("status result without end of run");

    a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !kind) |-> (status == ST_OK && rate_hz == '0 && channel_count == '0))
        else $error("sample result carries status fields");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind && status != ST_OK) |-> (rate_hz == '0 && !extra_chunks))
        else $error("error status carries format fields");
`endif

endmodule

>>> verif/tb_wav_pcm16_stream_parser.sv
// testbench for the riff/wave pcm16 stream parser: builds whole wav files,
// good and broken, feeds them byte by byte and checks every result beat
// depends on wavp_pkg and wav_pcm16_stream_parser
module tb_wav_pcm16_stream_parser;
    import wavp_pkg::*;

    // one expected or observed result beat
    typedef struct {
        bit                 kind;
        logic signed [15:0] sample;
        bit                 channel;
        bit [3:0]           status;
        bit [17:0]          rate_hz;
        bit [1:0]           channel_count;
        bit                 extra_chunks;
        bit                 end_of_run;
    } wav_result_t;

    // byte-level predictor of the parser plus the queue of expected beats
    class wav_scoreboard;
        bit [31:0]   max_in;
        bit [31:0]   max_pcm;
        bit [31:0]   nbytes;
        bit [31:0]   riff_len;
        bit [31:0]   tag_acc;
        phase_t      phase;
        chunk_kind_t ckind;
        bit [31:0]   clen;
        bit [31:0]   coff;
        bit [31:0]   fw[7];
        bit [2:0]    seen;
        bit [7:0]    low_hold;
        bit          chan_tog;
        bit [31:0]   pcm_len;
        bit [3:0]    err;
        int          fails;
        wav_result_t pending[$];
        int          word_of[18] = '{0,0,1,1,2,2,2,2,3,3,3,3,4,4,5,5,6,6};
        int          shift_of[18] = '{0,8,0,8,0,8,16,24,0,8,16,24,0,8,0,8,0,8};

        function new();
            max_in = '1;
            max_pcm = '1;
            fails = 0;
            clear();
        endfunction

        function void clear();
            nbytes = 0; riff_len = 0; tag_acc = 0;
            phase = PH_HEADER; ckind = CK_OTHER;
            clen = 0; coff = 0;
            foreach (fw[i]) fw[i] = 0;
            seen = 0; low_hold = 0; chan_tog = 0; pcm_len = 0; err = ST_OK;
        endfunction

        function void set_reg(bit idx, bit [31:0] val);
            if (idx == 1'b0) max_in = val;
            else max_pcm = val;
        endfunction

        function void halt(bit [3:0] code);
            err = code;
            phase = PH_DONE;
        endfunction

        function void open_chunk();
            logic [63:0] total;
            total = {32'd0, riff_len} + 64'd8;
            if ({32'd0, nbytes} >= total) begin
                phase = PH_DONE;
                return;
            end
            if (total - {32'd0, nbytes} < 64'd8) begin
                halt(ST_TRUNC_HDR);
                return;
            end
            phase = PH_CHUNK_HDR;
            coff = 0; clen = 0; tag_acc = 0;
        endfunction

        function void close_payload();
            if (ckind == CK_FMT) begin
                if (fw[0] != 1 || fw[5] != 16) begin
                    halt(ST_FMT_CODEC);
                    return;
                end
                if (fw[2] < RATE_MIN || fw[2] > RATE_MAX || (fw[1] != 1 && fw[1] != 2)) begin
                    halt(ST_FMT_RANGE);
                    return;
                end
                if ((clen != FMT_LEN && (clen != FMT_LEN_X || fw[6] != 0))
                    || fw[4] != fw[1] * 32'd2 || fw[3] != fw[2] * fw[1] * 32'd2) begin
                    halt(ST_FMT_SIZES);
                    return;
                end
                seen[SEEN_FMT] = 1'b1;
            end
            if (clen[0]) phase = PH_PAD;
            else open_chunk();
        endfunction

        function void header_end();
            logic [63:0] total;
            logic [63:0] padded;
            total = {32'd0, riff_len} + 64'd8;
            padded = {32'd0, clen} + clen[0];
            if (padded > total - {32'd0, nbytes}) begin
                halt(ST_TRUNC_BODY);
                return;
            end
            if (tag_acc == TAG_FMT) begin
                ckind = CK_FMT;
                if (seen[SEEN_FMT] || clen < FMT_LEN) begin
                    halt(ST_FMT_DUP);
                    return;
                end
                foreach (fw[i]) fw[i] = 0;
            end else if (tag_acc == TAG_DATA) begin
                ckind = CK_DATA;
                if (seen[SEEN_DATA] || !seen[SEEN_FMT]) begin
                    halt(ST_DATA_ORDER);
                    return;
                end
                pcm_len = clen;
                seen[SEEN_DATA] = 1'b1;
                chan_tog = 0;
            end else begin
                ckind = CK_OTHER;
                seen[SEEN_EXTRA] = 1'b1;
            end
            phase = PH_PAYLOAD;
            coff = 0;
            if (clen == 0) close_payload();
        endfunction

        function bit [3:0] file_status();
            bit [31:0] frame;
            frame = fw[1] * 32'd2;
            if (nbytes > max_in) return ST_TOO_LARGE;
            if (nbytes < 12 || err == ST_BAD_HEADER) return ST_BAD_HEADER;
            if ({32'd0, riff_len} + 64'd8 != {32'd0, nbytes}) return ST_RIFF_SIZE;
            if (err != ST_OK) return err;
            if (!seen[SEEN_FMT] || !seen[SEEN_DATA] || pcm_len == 0 || frame == 0
                || pcm_len % frame != 0) return ST_NO_PCM;
            if (pcm_len > max_pcm) return ST_PCM_LARGE;
            return ST_OK;
        endfunction

        // accepted input beat: advance the walk and queue its results
        function void note_byte(bit [7:0] b, bit last);
            bit [31:0]   idx;
            wav_result_t r;
            wav_result_t outs[$];
            bit [3:0]    st;
            idx = nbytes;
            if (nbytes != 32'hFFFF_FFFF) nbytes++;
            case (phase)
                PH_HEADER: begin
                    if (idx < 4 || (idx >= 8 && idx < 12)) tag_acc = {b, tag_acc[31:8]};
                    else if (idx < 8) riff_len |= {24'd0, b} << (8 * (idx - 4));
                    if (idx == 3 && tag_acc != TAG_RIFF) halt(ST_BAD_HEADER);
                    else if (idx == 11) begin
                        if (tag_acc != TAG_WAVE) halt(ST_BAD_HEADER);
                        else open_chunk();
                    end
                end
                PH_CHUNK_HDR: begin
                    if (coff < 4) tag_acc = {b, tag_acc[31:8]};
                    else clen |= {24'd0, b} << (8 * ((coff - 4) & 3));
                    coff++;
                    if (coff >= 8) header_end();
                end
                PH_PAYLOAD: begin
                    if (ckind == CK_FMT && coff < 18)
                        fw[word_of[coff]] |= {24'd0, b} << shift_of[coff];
                    else if (ckind == CK_DATA) begin
                        if (coff[0]) begin
                            r = '{default: 0};
                            r.sample = {b, low_hold};
                            r.channel = chan_tog;
                            outs.insert(outs.size(), r);
                            if (fw[1] == 2) chan_tog ^= 1'b1;
                        end else begin
                            low_hold = b;
                        end
                    end
                    coff++;
                    if (coff == clen) close_payload();
                end
                PH_PAD: open_chunk();
                default: ;
            endcase
            if (last) begin
                st = file_status();
                r = '{default: 0};
                r.kind = 1'b1;
                r.status = st;
                if (st == ST_OK) begin
                    r.rate_hz = fw[2][17:0];
                    r.channel_count = fw[1][1:0];
                    r.extra_chunks = seen[SEEN_EXTRA];
                end
                outs.insert(outs.size(), r);
                clear();
            end
            if (outs.size() > 0) outs[outs.size() - 1].end_of_run = 1'b1;
            foreach (outs[i]) pending.insert(pending.size(), outs[i]);
        endfunction

        // accepted result beat against the oldest expectation
        function void check_result(wav_result_t got);
            wav_result_t w;
            if (pending.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected result beat kind=%0d status=%0d",
                                          got.kind, got.status);
                return;
            end
            w = pending.pop_front();
            if (got.kind !== w.kind || got.sample !== w.sample || got.channel !== w.channel
                || got.status !== w.status || got.rate_hz !== w.rate_hz
                || got.channel_count !== w.channel_count
                || got.extra_chunks !== w.extra_chunks || got.end_of_run !== w.end_of_run) begin
                fails++;
                if (fails <= 10)
                    $display({"mismatch exp k=%0d s=%0d c=%0d st=%0d r=%0d cc=%0d x=%0d e=%0d",
                              " got k=%0d s=%0d c=%0d st=%0d r=%0d cc=%0d x=%0d e=%0d"},
                             w.kind, w.sample, w.channel, w.status, w.rate_hz,
                             w.channel_count, w.extra_chunks, w.end_of_run,
                             got.kind, got.sample, got.channel, got.status, got.rate_hz,
                             got.channel_count, got.extra_chunks, got.end_of_run);
            end
        endfunction
    endclass

    // file flavors produced by the generator
    typedef enum int {
        F_GOOD, F_EXTRA, F_FLIP, F_TRUNC, F_BADFMT, F_NOISE, F_DATA_FIRST,
        F_DUP_FMT, F_FMT18, F_ODD_DATA, F_RIFF_OFF, F_SHORT, F_NUM
    } file_mode_t;

    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [7:0]         data_byte;
    logic               is_last;
    logic               empty;
    logic               pop;
    logic               kind;
    logic signed [15:0] sample;
    logic               channel;
    logic [3:0]         status;
    logic [17:0]        rate_hz;
    logic [1:0]         channel_count;
    logic               extra_chunks;
    logic               end_of_run;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [31:0]        cfg_data;

    wav_scoreboard sb = new();
    bit [7:0]      file_q[$];
    int            burst_left = 0;
    int            gap_left = 0;
    int            bytes_sent = 0;
    int            cycles = 0;

    wav_pcm16_stream_parser DUT (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_wav_pcm16_stream_parser: FAIL");
            $finish;
        end
    end

    // receiver stall pattern, retuned at random
    int pop_mode = 0;
    always @(negedge clk)
    begin
        if (cycles % 64 == 0) pop_mode = $urandom_range(0, 3);
        case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 1);
            2: pop <= ((cycles % 4) == 0);
            default: pop <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // result beats are checked at the rising edge
    always @(posedge clk)
    begin
        wav_result_t got;
        if (rst_n && pop && !empty) begin
            got.kind = kind; got.sample = sample; got.channel = channel;
            got.status = status; got.rate_hz = rate_hz;
            got.channel_count = channel_count; got.extra_chunks = extra_chunks;
            got.end_of_run = end_of_run;
            sb.check_result(got);
        end
    end

    // one input beat; called and returns at a falling edge
    task automatic send_byte(input bit [7:0] b, input bit last);
        bit done;
        done = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        while (gap_left > 0) begin
            push <= 1'b0;
            @(negedge clk);
            gap_left--;
        end
        push <= 1'b1;
        data_byte <= b;
        is_last <= last;
        while (!done) begin
            @(posedge clk);
            if (!full) begin
                done = 1;
                sb.note_byte(b, last);
            end
            @(negedge clk);
        end
        burst_left--;
        bytes_sent++;
    endtask

    // wait until every expected beat has drained, then settle
    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input bit idx, input bit [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic void put_bytes(input bit [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_q.insert(file_q.size(), v[8*i +: 8]);
    endfunction

    // build one file into file_q
    task automatic build_file(input file_mode_t mode);
        bit [7:0]  body[$];
        bit [31:0] ch;
        bit [31:0] rate;
        bit [31:0] dlen;
        bit [31:0] flen;
        bit [31:0] riff;
        int        k;
        int        fmt_at;
        file_q.delete();
        if (mode == F_NOISE || mode == F_SHORT) begin
            k = (mode == F_SHORT) ? $urandom_range(1, 11) : $urandom_range(12, 40);
            for (int i = 0; i < k; i++) file_q.insert(file_q.size(), 8'($urandom_range(0, 255)));
            if (mode == F_NOISE && $urandom_range(0, 1)) begin
                put_bytes(TAG_RIFF, 4);
                file_q = file_q[k:$];
                file_q = {8'h52, 8'h49, 8'h46, 8'h46, file_q};
            end
            return;
        end
        ch = $urandom_range(1, 2);
        case ($urandom_range(0, 3))
            0: rate = RATE_MIN;
            1: rate = RATE_MAX;
            default: rate = $urandom_range(8000, 192000);
        endcase
        dlen = ch * 2 * $urandom_range(0, 6);
        if ($urandom_range(0, 9) == 0) dlen = ch * 2 * $urandom_range(7, 24);
        if (mode == F_ODD_DATA) dlen = dlen + 1;
        flen = (mode == F_FMT18) ? 18 : 16;
        // chunks are gathered in file_q then moved into body
        if (mode == F_EXTRA || $urandom_range(0, 4) == 0) begin
            put_bytes($urandom(), 4);
            k = $urandom_range(0, 5);
            put_bytes(k, 4);
            for (int i = 0; i < k + (k & 1); i++)
                file_q.insert(file_q.size(), 8'($urandom_range(0, 255)));
        end
        if (mode == F_DATA_FIRST) begin
            put_bytes(TAG_DATA, 4);
            put_bytes(2, 4);
            put_bytes($urandom(), 2);
        end
        fmt_at = file_q.size();
        put_bytes(TAG_FMT, 4);
        put_bytes(flen, 4);
        put_bytes(1, 2);
        put_bytes(ch, 2);
        put_bytes(rate, 4);
        put_bytes(rate * ch * 2, 4);
        put_bytes(ch * 2, 2);
        put_bytes(16, 2);
        if (flen == 18) put_bytes(($urandom_range(0, 3) == 0) ? 1 : 0, 2);
        if (mode == F_BADFMT) begin
            case ($urandom_range(0, 7))
                0: file_q[fmt_at + 8] = 3;
                1: file_q[fmt_at + 22] = 8;
                2: begin file_q[fmt_at + 12] = 8'h3F; file_q[fmt_at + 13] = 8'h1F;
                         file_q[fmt_at + 14] = 0; file_q[fmt_at + 15] = 0; end
                3: begin file_q[fmt_at + 12] = 8'h01; file_q[fmt_at + 13] = 8'hEE;
                         file_q[fmt_at + 14] = 8'h02; file_q[fmt_at + 15] = 0; end
                4: file_q[fmt_at + 10] = $urandom_range(0, 1) ? 0 : 3;
                5: file_q[fmt_at + 20] ^= 8'h01;
                6: file_q[fmt_at + 16] ^= 8'h04;
                default: file_q[fmt_at + 4] = $urandom_range(0, 15);
            endcase
        end
        if (mode == F_DUP_FMT) begin
            k = file_q.size();
            for (int i = fmt_at; i < k; i++) file_q.insert(file_q.size(), file_q[i]);
        end
        put_bytes(TAG_DATA, 4);
        put_bytes(dlen, 4);
        for (int i = 0; i < dlen; i++) file_q.insert(file_q.size(), 8'($urandom_range(0, 255)));
        if (dlen[0]) file_q.insert(file_q.size(), 8'h00);
        if ($urandom_range(0, 5) == 0) begin
            put_bytes($urandom(), 4);
            put_bytes(1, 4);
            put_bytes($urandom(), 2);
        end
        body = file_q;
        file_q.delete();
        riff = body.size() + 4;
        if (mode == F_RIFF_OFF) riff = riff + ($urandom_range(0, 1) ? 2 : -2);
        put_bytes(TAG_RIFF, 4);
        put_bytes(riff, 4);
        put_bytes(TAG_WAVE, 4);
        foreach (body[i]) file_q.insert(file_q.size(), body[i]);
        if (mode == F_FLIP) begin
            k = $urandom_range(0, file_q.size() - 1);
            file_q[k] ^= (8'h01 << $urandom_range(0, 7));
        end
        if (mode == F_TRUNC) begin
            k = $urandom_range(1, 12);
            repeat (k) if (file_q.size() > 1) void'(file_q.pop_back());
        end
    endtask

    task automatic send_file(input file_mode_t mode);
        build_file(mode);
        foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    task automatic pick_regs();
        bit [31:0] v;
        for (int r = 0; r < 2; r++) begin
            case ($urandom_range(0, 5))
                0: v = 0;
                1: v = 32'hFFFF_FFFF;
                2: v = $urandom_range(8, 120);
                default: v = 32'hFFFF_FFFF;
            endcase
            write_reg(r[0], v);
        end
    endtask

    initial
    begin
        file_mode_t m;
        int         files;
        rst_n = 1'b0;
        push = 1'b0;
        data_byte = 8'h00;
        is_last = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 32'd0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: one file of eight of the flavors, then register extremes
        send_file(F_GOOD);
        send_file(F_EXTRA);
        send_file(F_BADFMT);
        send_file(F_SHORT);
        send_file(F_DATA_FIRST);
        send_file(F_DUP_FMT);
        send_file(F_ODD_DATA);
        send_file(F_RIFF_OFF);
        drain();
        write_reg(1'b0, 32'd0);
        write_reg(1'b1, 32'd0);
        send_file(F_GOOD);
        drain();
        write_reg(1'b0, 32'hFFFF_FFFF);
        send_file(F_GOOD);
        drain();
        write_reg(1'b1, 32'd4);
        send_file(F_GOOD);
        drain();
        write_reg(1'b1, 32'hFFFF_FFFF);

        // random files, mostly well formed, up to the byte budget
        files = 0;
        while (bytes_sent < 450) begin
            if (files % 8 == 7) begin
                drain();
                pick_regs();
            end
            if ($urandom_range(0, 9) < 5) m = ($urandom_range(0, 1)) ? F_GOOD : F_EXTRA;
            else m = file_mode_t'($urandom_range(0, F_NUM - 1));
            send_file(m);
            files++;
        end

        drain();
        repeat (20) @(negedge clk);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("tb_wav_pcm16_stream_parser: PASS");
        else
            $display("tb_wav_pcm16_stream_parser: FAIL");
        $finish;
    end

endmodule
